### rtl/dltq_pkg.sv
// Shared types and codes for the delta-list timer queue.
// No dependencies; imported by delta_list_timer_queue_unit.
package dltq_pkg;

  localparam int TIMERS_DEF     = 16;
  localparam int COUNT_BITS_DEF = 16;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_START  = 2'd1,
    OP_CANCEL = 2'd2,
    OP_ACK    = 2'd3
  } opcode_t;

  // per-timer state
  typedef enum logic [1:0] {
    TS_IDLE   = 2'd0,
    TS_ACTIVE = 2'd1,
    TS_DONE   = 2'd2,
    TS_SPARE  = 2'd3
  } tstate_t;

  typedef enum logic [1:0] {
    RES_OK       = 2'd0,
    RES_BUSY     = 2'd1,
    RES_NOT_DONE = 2'd2
  } result_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISP,
    S_TK_ORD,
    S_TK_DEL,
    S_INFO,
    S_INS_CHK,
    S_INS_ORD,
    S_INS_DEL,
    S_INS_SH_RD,
    S_INS_SH_WR,
    S_INS_PLACE,
    S_INS_SUCC,
    S_RM_CHK,
    S_RM_ORD,
    S_RM_NXT,
    S_RM_D1,
    S_RM_D2,
    S_RM_SH_RD,
    S_RM_SH_WR,
    S_RESP
  } fsm_t;

endpackage

### rtl/dltq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dltq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/delta_list_timer_queue_unit.sv
// Delta-list timer queue: up to TIMERS one-shot or periodic timers kept in expiry order.
// Depends on dltq_pkg and dltq_ram.
//
// Usage: one request on the input channel (opcode, timer_id, length_ticks, periodic)
// gives exactly one result (status, expired_mask, active_count). Both channels use
// valid/ready. Requests are worked one at a time by a sequencer around three RAMs:
// the expiry order (a ring addressed from a head pointer), the per-timer deltas and
// the per-timer info word (state, periodic flag, length).
// Steps per request, as the one-read-per-cycle RAM ports require:
//   refused start or ack, plain ack, cancel of a timer not in the list: an info read only
//   tick: none if empty, else a read of the head entry and of each timer that expires
//   insert: a walk past earlier entries, a shift back of later ones, a successor update
//   cancel: a search for the entry, a shift forward of later ones, a successor update
// A new request is taken once the sequencer is idle, even while the previous result
// waits in the output register; if the receiver stalls, the next request holds at
// its last step.
// Reset (synchronous) empties the list and marks every timer idle through per-entry
// valid bits on the info RAM; no clearing pass is needed.
module delta_list_timer_queue_unit #(
  parameter int TIMERS     = dltq_pkg::TIMERS_DEF,
  parameter int COUNT_BITS = dltq_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [3:0]  timer_id,
  input  logic [15:0] length_ticks,
  input  logic        periodic,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] expired_mask,
  output logic [4:0]  active_count
);
  import dltq_pkg::*;

  localparam int ID_BITS   = $clog2(TIMERS);
  localparam int LEN_BITS  = $clog2(TIMERS + 1);
  localparam int CB        = COUNT_BITS;
  localparam int INFO_BITS = CB + 3;

  fsm_t state, state_next;

  logic [1:0]          op_q, op_next;
  logic [ID_BITS-1:0]  idx_q, idx_next;
  logic [CB-1:0]       lenin_q, lenin_next;
  logic                per_q, per_next;
  logic                inrange_q, inrange_next;
  logic [ID_BITS-1:0]  head, head_next;
  logic [LEN_BITS-1:0] list_len, list_len_next;
  logic [LEN_BITS-1:0] pos, pos_next;
  logic [LEN_BITS-1:0] sidx, sidx_next;
  logic [CB-1:0]       cnt, cnt_next;
  logic [ID_BITS-1:0]  cur_id, cur_id_next;
  logic [CB-1:0]       cur_delta, cur_delta_next;
  logic [15:0]         mask, mask_next;
  logic [1:0]          stat, stat_next;
  logic                first, first_next;
  logic                has_succ, has_succ_next;
  logic                load_out;

  logic [TIMERS-1:0]   vld;
  logic                vld_q;

  // RAM ports
  logic                 ord_we, del_we, inf_we;
  logic [ID_BITS-1:0]   ord_waddr, ord_raddr, del_waddr, del_raddr, inf_waddr, inf_raddr;
  logic [ID_BITS-1:0]   ord_wdata, ord_rdata;
  logic [CB-1:0]        del_wdata, del_rdata;
  logic [INFO_BITS-1:0] inf_wdata, inf_rdata;

  dltq_ram #(.WIDTH(ID_BITS), .DEPTH(TIMERS)) u_order (
    .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
    .raddr(ord_raddr), .rdata(ord_rdata)
  );
  dltq_ram #(.WIDTH(CB), .DEPTH(TIMERS)) u_delta (
    .clk(clk), .we(del_we), .waddr(del_waddr), .wdata(del_wdata),
    .raddr(del_raddr), .rdata(del_rdata)
  );
  dltq_ram #(.WIDTH(INFO_BITS), .DEPTH(TIMERS)) u_info (
    .clk(clk), .we(inf_we), .waddr(inf_waddr), .wdata(inf_wdata),
    .raddr(inf_raddr), .rdata(inf_rdata)
  );

  // list position to ring address
  function automatic logic [ID_BITS-1:0] ring(input logic [LEN_BITS-1:0] p);
    logic [31:0] s;
    s = 32'(head) + 32'(p);
    if (s >= 32'(TIMERS)) s = s - 32'(TIMERS);
    return s[ID_BITS-1:0];
  endfunction

  // info word of the last read, idle when never written
  logic [1:0]    inf_st;
  logic          inf_per;
  logic [CB-1:0] inf_len;
  assign inf_st  = vld_q ? inf_rdata[CB+2:CB+1] : TS_IDLE;
  assign inf_per = vld_q ? inf_rdata[CB] : 1'b0;
  assign inf_len = vld_q ? inf_rdata[CB-1:0] : '0;

  logic [31:0]   id_wide, len_wide;
  logic [CB-1:0] dec_delta, start_len;
  assign id_wide   = 32'(timer_id);
  assign len_wide  = 32'(length_ticks);
  assign dec_delta = (first && del_rdata != '0) ? del_rdata - 1'b1 : del_rdata;
  assign start_len = (lenin_q == '0) ? CB'(1) : lenin_q;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    op_next       = op_q;
    idx_next      = idx_q;
    lenin_next    = lenin_q;
    per_next      = per_q;
    inrange_next  = inrange_q;
    head_next     = head;
    list_len_next = list_len;
    pos_next      = pos;
    sidx_next     = sidx;
    cnt_next      = cnt;
    cur_id_next   = cur_id;
    cur_delta_next = cur_delta;
    mask_next     = mask;
    stat_next     = stat;
    first_next    = first;
    has_succ_next = has_succ;
    load_out      = 1'b0;
    ord_we = 1'b0; ord_waddr = '0; ord_wdata = '0; ord_raddr = '0;
    del_we = 1'b0; del_waddr = '0; del_wdata = '0; del_raddr = '0;
    inf_we = 1'b0; inf_waddr = '0; inf_wdata = '0; inf_raddr = '0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_next      = opcode;
          idx_next     = id_wide[ID_BITS-1:0];
          inrange_next = id_wide < 32'(TIMERS);
          lenin_next   = len_wide[CB-1:0];
          per_next     = periodic;
          mask_next    = '0;
          stat_next    = RES_OK;
          state_next   = S_DISP;
        end
      end
      S_DISP: begin
        if (op_q == OP_TICK) begin
          if (list_len == '0) begin
            state_next = S_RESP;
          end else begin
            ord_raddr  = ring('0);
            first_next = 1'b1;
            state_next = S_TK_ORD;
          end
        end else if (!inrange_q) begin
          state_next = S_RESP;
        end else begin
          inf_raddr  = idx_q;
          state_next = S_INFO;
        end
      end
      S_TK_ORD: begin
        cur_id_next = ord_rdata;
        del_raddr   = ord_rdata;
        inf_raddr   = ord_rdata;
        state_next  = S_TK_DEL;
      end
      S_TK_DEL: begin
        first_next = 1'b0;
        if (dec_delta != '0) begin
          del_we     = 1'b1;
          del_waddr  = cur_id;
          del_wdata  = dec_delta;
          state_next = S_RESP;
        end else begin
          // expire the head and drop it from the ring
          inf_we        = 1'b1;
          inf_waddr     = cur_id;
          inf_wdata     = {TS_DONE, inf_per, inf_len};
          mask_next     = mask | 16'(64'd1 << cur_id);
          head_next     = ring(LEN_BITS'(1));
          list_len_next = list_len - 1'b1;
          if (list_len == LEN_BITS'(1)) begin
            state_next = S_RESP;
          end else begin
            ord_raddr  = ring(LEN_BITS'(1));
            state_next = S_TK_ORD;
          end
        end
      end
      S_INFO: begin
        pos_next = '0;
        unique case (op_q)
          OP_START: begin
            if (inf_st != TS_IDLE) begin
              stat_next  = RES_BUSY;
              state_next = S_RESP;
            end else begin
              inf_we     = 1'b1;
              inf_waddr  = idx_q;
              inf_wdata  = {TS_ACTIVE, per_q, start_len};
              cnt_next   = start_len;
              state_next = S_INS_CHK;
            end
          end
          OP_CANCEL: begin
            inf_we     = 1'b1;
            inf_waddr  = idx_q;
            inf_wdata  = {TS_IDLE, inf_per, inf_len};
            state_next = (inf_st == TS_ACTIVE) ? S_RM_CHK : S_RESP;
          end
          OP_ACK: begin
            if (inf_st != TS_DONE) begin
              stat_next  = RES_NOT_DONE;
              state_next = S_RESP;
            end else if (inf_per) begin
              inf_we     = 1'b1;
              inf_waddr  = idx_q;
              inf_wdata  = {TS_ACTIVE, inf_per, inf_len};
              cnt_next   = inf_len;
              state_next = S_INS_CHK;
            end else begin
              inf_we     = 1'b1;
              inf_waddr  = idx_q;
              inf_wdata  = {TS_IDLE, inf_per, inf_len};
              state_next = S_RESP;
            end
          end
          default: state_next = S_RESP;
        endcase
      end
      S_INS_CHK: begin
        if (pos < list_len) begin
          ord_raddr  = ring(pos);
          state_next = S_INS_ORD;
        end else begin
          has_succ_next = 1'b0;
          sidx_next     = list_len;
          state_next    = S_INS_SH_RD;
        end
      end
      S_INS_ORD: begin
        cur_id_next = ord_rdata;
        del_raddr   = ord_rdata;
        state_next  = S_INS_DEL;
      end
      S_INS_DEL: begin
        if (cnt >= del_rdata) begin
          cnt_next   = cnt - del_rdata;
          pos_next   = pos + 1'b1;
          state_next = S_INS_CHK;
        end else begin
          cur_delta_next = del_rdata;
          has_succ_next  = 1'b1;
          sidx_next      = list_len;
          state_next     = S_INS_SH_RD;
        end
      end
      S_INS_SH_RD: begin
        // move the tail back by one, from the end down to the slot
        if (sidx > pos) begin
          ord_raddr  = ring(sidx - 1'b1);
          state_next = S_INS_SH_WR;
        end else begin
          state_next = S_INS_PLACE;
        end
      end
      S_INS_SH_WR: begin
        ord_we     = 1'b1;
        ord_waddr  = ring(sidx);
        ord_wdata  = ord_rdata;
        sidx_next  = sidx - 1'b1;
        state_next = S_INS_SH_RD;
      end
      S_INS_PLACE: begin
        ord_we        = 1'b1;
        ord_waddr     = ring(pos);
        ord_wdata     = idx_q;
        del_we        = 1'b1;
        del_waddr     = idx_q;
        del_wdata     = cnt;
        list_len_next = list_len + 1'b1;
        state_next    = has_succ ? S_INS_SUCC : S_RESP;
      end
      S_INS_SUCC: begin
        del_we     = 1'b1;
        del_waddr  = cur_id;
        del_wdata  = cur_delta - cnt;
        state_next = S_RESP;
      end
      S_RM_CHK: begin
        if (pos < list_len) begin
          ord_raddr  = ring(pos);
          state_next = S_RM_ORD;
        end else begin
          state_next = S_RESP;
        end
      end
      S_RM_ORD: begin
        if (ord_rdata == idx_q) begin
          sidx_next = pos;
          if ((32'(pos) + 32'd1) < 32'(list_len)) begin
            ord_raddr  = ring(pos + 1'b1);
            state_next = S_RM_NXT;
          end else begin
            state_next = S_RM_SH_RD;
          end
        end else begin
          pos_next   = pos + 1'b1;
          state_next = S_RM_CHK;
        end
      end
      S_RM_NXT: begin
        cur_id_next = ord_rdata;
        del_raddr   = ord_rdata;
        state_next  = S_RM_D1;
      end
      S_RM_D1: begin
        cur_delta_next = del_rdata;
        del_raddr      = idx_q;
        state_next     = S_RM_D2;
      end
      S_RM_D2: begin
        // hand the removed delta to the successor
        del_we     = 1'b1;
        del_waddr  = cur_id;
        del_wdata  = cur_delta + del_rdata;
        state_next = S_RM_SH_RD;
      end
      S_RM_SH_RD: begin
        if ((32'(sidx) + 32'd1) < 32'(list_len)) begin
          ord_raddr  = ring(sidx + 1'b1);
          state_next = S_RM_SH_WR;
        end else begin
          list_len_next = list_len - 1'b1;
          state_next    = S_RESP;
        end
      end
      S_RM_SH_WR: begin
        ord_we     = 1'b1;
        ord_waddr  = ring(sidx);
        ord_wdata  = ord_rdata;
        sidx_next  = sidx + 1'b1;
        state_next = S_RM_SH_RD;
      end
      S_RESP: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      list_len <= '0;
      vld      <= '0;
      first    <= 1'b0;
      has_succ <= 1'b0;
    end else begin
      state    <= state_next;
      head     <= head_next;
      list_len <= list_len_next;
      first    <= first_next;
      has_succ <= has_succ_next;
      if (inf_we) vld[inf_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    op_q      <= op_next;
    idx_q     <= idx_next;
    lenin_q   <= lenin_next;
    per_q     <= per_next;
    inrange_q <= inrange_next;
    pos       <= pos_next;
    sidx      <= sidx_next;
    cnt       <= cnt_next;
    cur_id    <= cur_id_next;
    cur_delta <= cur_delta_next;
    mask      <= mask_next;
    stat      <= stat_next;
    vld_q     <= vld[inf_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status       <= stat;
      expired_mask <= mask;
      active_count <= 5'(list_len);
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    32'(list_len) <= 32'(TIMERS))
    else $error("list length beyond capacity");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while one is in work");

  a_succ_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS_SUCC) |-> (cnt < cur_delta))
    else $error("successor delta would wrap on insert");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid)
    else $error("result not presented after completion");

endmodule

### sim/tb_delta_list_timer_queue_unit.sv
// Testbench for delta_list_timer_queue_unit: random tick/start/cancel/ack requests
// checked against an in-bench delta-list predictor. Depends on dltq_pkg and the RTL.
module tb_delta_list_timer_queue_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import dltq_pkg::*;

  typedef struct packed {
    logic [1:0]  st;
    logic [15:0] mask;
    logic [4:0]  cnt;
  } timer_resp_t;

  class timer_scoreboard;
    tstate_t     tstate [16];
    bit          is_per [16];
    logic [15:0] tlen   [16];
    logic [15:0] tdelta [16];
    logic [3:0]  order  [16];
    int          nlist;
    timer_resp_t pending[$];
    int          errors;

    function void clear();
      for (int i = 0; i < 16; i++) begin
        tstate[i] = TS_IDLE; is_per[i] = 0; tlen[i] = 0; tdelta[i] = 0; order[i] = 0;
      end
      nlist = 0;
      errors = 0;
    endfunction

    function void place(int id);
      logic [15:0] c;
      int p;
      c = tlen[id];
      p = 0;
      while (p < nlist && c >= tdelta[order[p]]) begin
        c -= tdelta[order[p]];
        p++;
      end
      for (int i = nlist; i > p; i--) order[i] = order[i-1];
      order[p] = 4'(id);
      tdelta[id] = c;
      nlist++;
      if (p + 1 < nlist) tdelta[order[p+1]] -= c;
    endfunction

    function void unlink(int id);
      int p;
      p = 0;
      while (p < nlist && order[p] != id) p++;
      if (p >= nlist) return;
      if (p + 1 < nlist) tdelta[order[p+1]] += tdelta[id];
      for (int i = p; i + 1 < nlist; i++) order[i] = order[i+1];
      nlist--;
    endfunction

    function void note_request(logic [1:0] op, logic [3:0] id, logic [15:0] len, bit per);
      timer_resp_t r;
      int t;
      r = '0;
      if (op == OP_TICK) begin
        if (nlist > 0) begin
          if (tdelta[order[0]] > 0) tdelta[order[0]]--;
          while (nlist > 0 && tdelta[order[0]] == 0) begin
            t = int'(order[0]);
            tstate[t] = TS_DONE;
            r.mask[t] = 1'b1;
            for (int i = 0; i + 1 < nlist; i++) order[i] = order[i+1];
            nlist--;
          end
        end
      end else if (op == OP_START) begin
        if (tstate[id] != TS_IDLE) r.st = RES_BUSY;
        else begin
          tstate[id] = TS_ACTIVE;
          is_per[id] = per;
          tlen[id] = (len == 0) ? 16'd1 : len;
          place(id);
        end
      end else if (op == OP_CANCEL) begin
        if (tstate[id] == TS_ACTIVE) unlink(id);
        tstate[id] = TS_IDLE;
      end else begin
        if (tstate[id] != TS_DONE) r.st = RES_NOT_DONE;
        else if (is_per[id]) begin
          tstate[id] = TS_ACTIVE;
          place(id);
        end else tstate[id] = TS_IDLE;
      end
      r.cnt = 5'(nlist);
      pending.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [15:0] mask, logic [4:0] cnt);
      timer_resp_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result st=%0d mask=%h cnt=%0d", $realtime, st, mask, cnt);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (st !== e.st) begin
        $display("%0t: status exp %0d got %0d", $realtime, e.st, st); errors++;
      end
      if (mask !== e.mask) begin
        $display("%0t: expired_mask exp %h got %h", $realtime, e.mask, mask); errors++;
      end
      if (cnt !== e.cnt) begin
        $display("%0t: active_count exp %0d got %0d", $realtime, e.cnt, cnt); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0, periodic = 0;
  logic [1:0] opcode = 0, status;
  logic [3:0] timer_id = 0;
  logic [15:0] length_ticks = 0, expired_mask;
  logic [4:0] active_count;
  bit stall_mode = 0;

  timer_scoreboard sb;

  delta_list_timer_queue_unit DUT (.*);

  initial forever #6 clk = ~clk;

  initial begin
    #40ms;
    $display("DONE: errors detected");
    $finish;
  end

  // receiver: bursts of stalls on its own pattern
  always @(posedge clk) begin
    if (out_valid && out_ready) sb.check_result(status, expired_mask, active_count);
    if (stall_mode) out_ready <= ($urandom_range(0, 3) != 0);
    else out_ready <= 1'b1;
  end

  always @(posedge clk) if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;

  task automatic send_request(logic [1:0] op, logic [3:0] id, logic [15:0] len, bit per);
    opcode <= op; timer_id <= id; length_ticks <= len; periodic <= per;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_request(op, id, len, per);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] pick_len();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(1, 12));
    endcase
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    int burst;
    logic [1:0] op;
    sb = new();
    sb.clear();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: empty tick, extremes, refusals, cancel of last and of idle
    send_request(OP_TICK, 4'd0, 16'd0, 0);
    send_request(OP_ACK, 4'd3, 16'd0, 0);
    send_request(OP_START, 4'd0, 16'd0, 0);
    send_request(OP_START, 4'd15, 16'hFFFF, 1);
    send_request(OP_START, 4'd0, 16'd5, 1);
    send_request(OP_START, 4'd7, 16'd3, 1);
    send_request(OP_START, 4'd8, 16'd3, 0);
    send_request(OP_TICK, 4'd0, 16'd0, 0);
    send_request(OP_ACK, 4'd0, 16'd0, 0);
    send_request(OP_CANCEL, 4'd15, 16'd0, 0);
    send_request(OP_CANCEL, 4'd4, 16'd0, 0);
    send_request(OP_TICK, 4'd0, 16'd0, 0);
    send_request(OP_TICK, 4'd0, 16'd0, 0);
    send_request(OP_TICK, 4'd0, 16'd0, 0);
    send_request(OP_ACK, 4'd7, 16'd0, 0);
    send_request(OP_ACK, 4'd8, 16'd0, 0);
    send_request(OP_CANCEL, 4'd7, 16'd0, 0);
    send_request(OP_CANCEL, 4'd0, 16'd0, 0);
    // hold the sender until everything has drained
    drain();
    for (int n = 0; n < 900; ) begin
      burst = $urandom_range(1, 20);
      for (int k = 0; k < burst; k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: op = OP_TICK;
          4, 5, 6: op = OP_START;
          7: op = OP_CANCEL;
          default: op = OP_ACK;
        endcase
        send_request(op, 4'($urandom), pick_len(), 1'($urandom));
        n++;
      end
      if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 30));
      if (n > 450 && n < 470) drain();
    end
    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

### filelist.f
rtl/dltq_pkg.sv
rtl/dltq_ram.sv
rtl/delta_list_timer_queue_unit.sv
sim/tb_delta_list_timer_queue_unit.sv
